@@ src/foe_pkg.sv @@
`timescale 1ns / 1ps
package foe_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    // register indexes
    localparam logic [2:0] REG_RES  = 3'd0;
    localparam logic [2:0] REG_IND  = 3'd1;
    localparam logic [2:0] REG_LAM  = 3'd2;
    localparam logic [2:0] REG_GAM  = 3'd3;
    localparam logic [2:0] REG_KP   = 3'd4;
    localparam logic [2:0] REG_KI   = 3'd5;
    localparam logic [2:0] REG_DT   = 3'd6;
    localparam logic [2:0] REG_COEF = 3'd7;

    localparam logic signed [63:0] LIM47     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM62     = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] LIM31     = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MAX48U    = 64'sh0000_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q32   = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] PI_Q32    = 64'sd13493037705;
    localparam logic signed [63:0] INVPI_Q32 = 64'sd1367130551;
    localparam logic signed [63:0] LOCK_VAR  = 64'sd32212255;
    localparam logic signed [63:0] UNLOCK_VAR = LOCK_VAR * 4;
    localparam logic signed [63:0] LOCK_MAG  = 64'sd858993459;
    localparam logic signed [63:0] UNLOCK_MAG = LOCK_MAG / 4;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         sh;
        logic               lim62;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } t_mul_rsp;

    function automatic logic signed [63:0] sat_to(input logic signed [63:0] v,
                                                  input logic signed [63:0] lim);
        logic signed [63:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim - 64'sd1) begin
            r = -lim - 64'sd1;
        end
        return r;
    endfunction

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

@@ src/foe_mul.sv @@
`timescale 1ns / 1ps
module foe_mul import foe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);
    // sign-magnitude 64x64 multiply, one 32x32 partial product per cycle,
    // then round half away from zero, shift and saturate
    logic               r_busy;
    logic               r_rnd;
    logic [1:0]         r_cnt;
    logic [63:0]        r_ua;
    logic [63:0]        r_ub;
    logic               r_neg;
    logic [5:0]         r_sh;
    logic               r_lim62;
    logic [127:0]       r_acc;
    logic               r_done;
    logic signed [63:0] r_res;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [63:0]  w_pp;
    logic [6:0]   w_ppsft;
    logic [127:0] w_sum;
    logic [127:0] w_q;
    logic [127:0] w_cap;
    logic [63:0]  w_mag;

    always_comb begin
        w_ah    = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
        w_bh    = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
        w_pp    = w_ah * w_bh;
        w_ppsft = {4'd0, ({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]}), 1'b0} << 4;
        w_sum   = r_acc + (128'd1 << (r_sh - 6'd1));
        w_q     = w_sum >> r_sh;
        if (r_lim62) begin
            w_cap = r_neg ? 128'h4000_0000_0000_0000 : 128'h3FFF_FFFF_FFFF_FFFF;
        end else begin
            w_cap = r_neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        end
        w_mag = (w_q > w_cap) ? w_cap[63:0] : w_q[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_rnd   <= 1'b0;
                r_cnt   <= 2'd0;
                r_ua    <= i_req.a[63] ? 64'(-i_req.a) : i_req.a;
                r_ub    <= i_req.b[63] ? 64'(-i_req.b) : i_req.b;
                r_neg   <= i_req.a[63] ^ i_req.b[63];
                r_sh    <= i_req.sh;
                r_lim62 <= i_req.lim62;
                r_acc   <= '0;
            end else if (r_busy && !r_rnd) begin
                r_acc <= r_acc + ({64'd0, w_pp} << w_ppsft);
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_rnd <= 1'b1;
                end
            end else if (r_busy && r_rnd) begin
                r_res  <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                r_done <= 1'b1;
                r_busy <= 1'b0;
                r_rnd  <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule

@@ src/flux_observer_pll_angle_estimator_core.sv @@
`timescale 1ns / 1ps
// Sensorless angle estimator: flux-linkage observer, vectoring CORDIC on the
// magnet flux and a PI PLL with a variance/magnitude lock detector. One item
// is processed at a time; all products go through a single shared multiplier
// (four 32x32 partial products plus a rounding step per product). After the 23
// products, the CORDIC_STEPS rotations and the control states, the result
// is written to the output register, once the previous result has left it, in
// the same cycle as the input becomes ready again. The result sits there, so
// the next item is taken while it waits.
module flux_observer_pll_angle_estimator_core import foe_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_current_alpha,
    input  logic signed [31:0] i_current_beta,
    input  logic signed [31:0] i_voltage_alpha,
    input  logic signed [31:0] i_voltage_beta,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_rotor_angle,
    output logic signed [31:0] o_rotor_speed,
    output logic               o_lock_flag
);
    localparam int CW = $clog2(CORDIC_STEPS);

    localparam logic [4:0] S_IDLE = 5'd0,  S_Y0   = 5'd1,  S_Y1   = 5'd2,  S_LI0 = 5'd3,
                           S_LI1  = 5'd4,  S_MG0  = 5'd5,  S_MG1  = 5'd6,  S_LAM = 5'd7,
                           S_SCL  = 5'd8,  S_X0   = 5'd9,  S_F0   = 5'd10, S_X1  = 5'd11,
                           S_F1   = 5'd12, S_CINI = 5'd13, S_CIT  = 5'd14, S_CEND = 5'd15,
                           S_DRAD = 5'd16, S_RATE = 5'd17, S_T1   = 5'd18, S_T2  = 5'd19,
                           S_I1   = 5'd20, S_I2   = 5'd21, S_DSQ  = 5'd22, S_V1  = 5'd23,
                           S_V2   = 5'd24, S_PM0  = 5'd25, S_PM1  = 5'd26, S_DONE = 5'd27;

    logic [47:0] r_res, r_ind, r_lam, r_gam, r_kp, r_ki, r_dt;
    logic [32:0] r_coef;

    logic signed [47:0] r_fe0, r_fe1;
    logic [15:0]        r_angle;
    logic signed [31:0] r_speed;
    logic [47:0]        r_var;
    logic               r_lock;

    logic [4:0]         r_state;
    logic               r_issued;
    logic signed [31:0] r_cur0, r_cur1, r_v0, r_v1;
    logic signed [63:0] r_y0, r_y1, r_li0, r_li1, r_eta0, r_eta1;
    logic signed [63:0] r_acc, r_diff, r_scale, r_xdot, r_pm0, r_pm1;
    logic signed [63:0] r_drad, r_rate, r_tmp, r_dsq;
    logic signed [51:0] r_cx, r_cy;
    logic [31:0]        r_cz;
    logic               r_czero;
    logic [CW-1:0]      r_cit;
    logic signed [15:0] r_d;

    logic               r_ovalid;
    logic [15:0]        r_oangle;
    logic signed [31:0] r_ospeed;
    logic               r_olock;

    t_mul_req w_req;
    t_mul_rsp w_rsp;
    logic signed [63:0] w_a, w_b, w_fsum, w_m;
    logic [5:0]         w_sh;
    logic               w_lim62;
    logic [32:0]        w_c;
    logic signed [51:0] w_dx, w_dy;
    logic [15:0]        w_fa;

    assign w_c = (r_coef > 33'h1_0000_0000) ? 33'h1_0000_0000 : r_coef;

    // shared multiplier operand select
    always_comb begin
        w_a     = '0;
        w_b     = '0;
        w_sh    = 6'd32;
        w_lim62 = 1'b0;
        case (r_state)
            S_Y0:   begin w_a = {16'd0, r_res}; w_b = 64'(r_cur0); w_sh = 6'd16; end
            S_Y1:   begin w_a = {16'd0, r_res}; w_b = 64'(r_cur1); w_sh = 6'd16; end
            S_LI0:  begin w_a = {16'd0, r_ind}; w_b = 64'(r_cur0); w_sh = 6'd16; end
            S_LI1:  begin w_a = {16'd0, r_ind}; w_b = 64'(r_cur1); w_sh = 6'd16; end
            S_MG0:  begin w_a = r_eta0; w_b = r_eta0; end
            S_MG1:  begin w_a = r_eta1; w_b = r_eta1; end
            S_LAM:  begin w_a = {16'd0, r_lam}; w_b = {16'd0, r_lam}; end
            S_SCL:  begin w_a = {16'd0, r_gam}; w_b = r_diff; w_sh = 6'd17; end
            S_X0:   begin w_a = r_scale; w_b = r_eta0; end
            S_F0:   begin w_a = r_xdot; w_b = {16'd0, r_dt}; end
            S_X1:   begin w_a = r_scale; w_b = r_eta1; end
            S_F1:   begin w_a = r_xdot; w_b = {16'd0, r_dt}; end
            S_DRAD: begin w_a = 64'(r_d); w_b = PI_Q32; w_sh = 6'd15; w_lim62 = 1'b1; end
            S_RATE: begin w_a = {16'd0, r_kp}; w_b = r_drad; w_sh = 6'd16; w_lim62 = 1'b1; end
            S_T1:   begin w_a = r_rate; w_b = {16'd0, r_dt}; w_lim62 = 1'b1; end
            S_T2:   begin w_a = r_tmp; w_b = INVPI_Q32; w_sh = 6'd49; w_lim62 = 1'b1; end
            S_I1:   begin w_a = {16'd0, r_ki}; w_b = r_drad; w_sh = 6'd16; w_lim62 = 1'b1; end
            S_I2:   begin w_a = r_tmp; w_b = {16'd0, r_dt}; w_sh = 6'd48; w_lim62 = 1'b1; end
            S_DSQ:  begin w_a = r_drad; w_b = r_drad; w_lim62 = 1'b1; end
            S_V1:   begin
                w_a = {16'd0, r_var}; w_b = ONE_Q32 - {31'd0, w_c}; w_lim62 = 1'b1;
            end
            S_V2:   begin w_a = {31'd0, w_c}; w_b = r_dsq; w_lim62 = 1'b1; end
            S_PM0:  begin w_a = r_pm0; w_b = r_pm0; w_lim62 = 1'b1; end
            S_PM1:  begin w_a = r_pm1; w_b = r_pm1; w_lim62 = 1'b1; end
            default: begin w_a = '0; end
        endcase
        w_req.start = !r_issued && (r_state != S_IDLE) && (r_state != S_CINI) &&
                      (r_state != S_CIT) && (r_state != S_CEND) && (r_state != S_DONE);
        w_req.a     = w_a;
        w_req.b     = w_b;
        w_req.sh    = w_sh;
        w_req.lim62 = w_lim62;
    end

    foe_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign w_fsum = sat_to(((r_state == S_F0) ? 64'(r_fe0) : 64'(r_fe1)) + w_rsp.res, LIM47);
    assign w_m    = r_acc + w_rsp.res;
    assign w_dx   = r_cy >>> r_cit;
    assign w_dy   = r_cx >>> r_cit;
    assign w_fa   = r_czero ? 16'd0 : 16'((33'(r_cz) + 33'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res    <= 48'd429496730;
            r_ind    <= 48'd42950;
            r_lam    <= 48'd21474836;
            r_gam    <= 48'd327680000000;
            r_kp     <= 48'd2621440;
            r_ki     <= 48'd2621440000;
            r_dt     <= 48'd536871;
            r_coef   <= 33'd5365356;
            r_fe0    <= '0;
            r_fe1    <= '0;
            r_angle  <= '0;
            r_speed  <= '0;
            r_var    <= 48'h000A_0000_0000;
            r_lock   <= 1'b0;
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RES:  r_res  <= i_cfg_data;
                    REG_IND:  r_ind  <= i_cfg_data;
                    REG_LAM:  r_lam  <= i_cfg_data;
                    REG_GAM:  r_gam  <= i_cfg_data;
                    REG_KP:   r_kp   <= i_cfg_data;
                    REG_KI:   r_ki   <= i_cfg_data;
                    REG_DT:   r_dt   <= i_cfg_data;
                    REG_COEF: r_coef <= i_cfg_data[32:0];
                    default:  r_coef <= r_coef;
                endcase
            end

            if (r_ovalid && i_ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            if (w_req.start) begin
                r_issued <= 1'b1;
            end
            if (w_rsp.done) begin
                r_issued <= 1'b0;
                r_state  <= r_state + 5'd1;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cur0  <= i_current_alpha;
                        r_cur1  <= i_current_beta;
                        r_v0    <= i_voltage_alpha;
                        r_v1    <= i_voltage_beta;
                        r_state <= S_Y0;
                    end
                end
                S_Y0: if (w_rsp.done) r_y0 <= sat_to({{16{r_v0[31]}}, r_v0, 16'd0} - w_rsp.res, LIM47);
                S_Y1: if (w_rsp.done) r_y1 <= sat_to({{16{r_v1[31]}}, r_v1, 16'd0} - w_rsp.res, LIM47);
                S_LI0: begin
                    if (w_rsp.done) begin
                        r_li0  <= w_rsp.res;
                        r_eta0 <= sat_to(64'(r_fe0) - w_rsp.res, LIM47);
                    end
                end
                S_LI1: begin
                    if (w_rsp.done) begin
                        r_li1  <= w_rsp.res;
                        r_eta1 <= sat_to(64'(r_fe1) - w_rsp.res, LIM47);
                    end
                end
                S_MG0: if (w_rsp.done) r_acc <= w_rsp.res;
                S_MG1: if (w_rsp.done) r_acc <= sat_to(w_m, LIM47);
                S_LAM: if (w_rsp.done) r_diff <= sat_to(w_rsp.res - r_acc, LIM47);
                S_SCL: if (w_rsp.done) r_scale <= w_rsp.res;
                S_X0:  if (w_rsp.done) r_xdot <= sat_to(r_y0 + w_rsp.res, LIM47);
                S_F0: begin
                    if (w_rsp.done) begin
                        r_fe0 <= w_fsum[47:0];
                        r_pm0 <= sat_to(w_fsum - r_li0, LIM47);
                    end
                end
                S_X1:  if (w_rsp.done) r_xdot <= sat_to(r_y1 + w_rsp.res, LIM47);
                S_F1: begin
                    if (w_rsp.done) begin
                        r_fe1 <= w_fsum[47:0];
                        r_pm1 <= sat_to(w_fsum - r_li1, LIM47);
                    end
                end
                S_CINI: begin
                    r_czero <= (r_pm0 == 64'sd0) && (r_pm1 == 64'sd0);
                    r_cit   <= '0;
                    if (r_pm0 < 64'sd0) begin
                        r_cx <= -r_pm0[51:0];
                        r_cy <= -r_pm1[51:0];
                        r_cz <= 32'h8000_0000;
                    end else begin
                        r_cx <= r_pm0[51:0];
                        r_cy <= r_pm1[51:0];
                        r_cz <= 32'h0;
                    end
                    r_state <= S_CIT;
                end
                S_CIT: begin
                    if (r_cy < 52'sd0) begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - atan_turn(5'(r_cit));
                    end else begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + atan_turn(5'(r_cit));
                    end
                    r_cit <= r_cit + 1'b1;
                    if (r_cit == CW'(CORDIC_STEPS - 1)) begin
                        r_state <= S_CEND;
                    end
                end
                S_CEND: begin
                    r_d     <= $signed(w_fa - r_angle);
                    r_state <= S_DRAD;
                end
                S_DRAD: if (w_rsp.done) r_drad <= w_rsp.res;
                S_RATE: begin
                    if (w_rsp.done) begin
                        r_rate <= sat_to({{16{r_speed[31]}}, r_speed, 16'd0} + w_rsp.res, LIM62);
                    end
                end
                S_T1: if (w_rsp.done) r_tmp <= w_rsp.res;
                S_T2: if (w_rsp.done) r_angle <= r_angle + w_rsp.res[15:0];
                S_I1: if (w_rsp.done) r_tmp <= w_rsp.res;
                S_I2: begin
                    if (w_rsp.done) begin
                        r_speed <= 32'(sat_to(64'(r_speed) + w_rsp.res, LIM31));
                    end
                end
                S_DSQ: if (w_rsp.done) r_dsq <= w_rsp.res;
                S_V1:  if (w_rsp.done) r_acc <= w_rsp.res;
                S_V2:  if (w_rsp.done) r_var <= (w_m > MAX48U) ? MAX48U[47:0] : w_m[47:0];
                S_PM0: if (w_rsp.done) r_acc <= w_rsp.res;
                S_PM1: begin
                    if (w_rsp.done) begin
                        if (r_lock) begin
                            if ((64'(r_var) > UNLOCK_VAR) || (w_m < UNLOCK_MAG)) begin
                                r_lock <= 1'b0;
                            end
                        end else if ((64'(r_var) < LOCK_VAR) && (w_m > LOCK_MAG)) begin
                            r_lock <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the previous item leaves the output register
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_oangle <= r_angle;
                        r_ospeed <= r_speed;
                        r_olock  <= r_lock;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_rotor_angle = $signed(r_oangle);
    assign o_rotor_speed = r_ospeed;
    assign o_lock_flag   = r_olock;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a second item while busy");
    a_mul_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_issued)
        else $error("product returned without a request");
    a_lock_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_lock) |-> (64'(r_var) < LOCK_VAR))
        else $error("lock set with high phase error variance");
    a_cordic_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CIT) |-> (r_cit <= CW'(CORDIC_STEPS - 1)))
        else $error("rotation count out of range");
endmodule
